@@ design/fmts_pkg.sv @@
// ----------------------------------------------------------------------------
// Flow meter package
// Shared widths, constants, queue item and state types for the flow meter.
// ----------------------------------------------------------------------------
package fmts_pkg;

  // Sizing of the rate path.
  localparam int HIST_DEPTH = 10;
  localparam int RATE_W     = 24;
  localparam int COUNT_W    = 16;

  // Fixed widths of the configuration registers.
  localparam int TIMEOUT_W = 16;
  localparam int NUM_W     = 32;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMER   = 2'd1;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd510;
  localparam logic [NUM_W-1:0]     NUMER_RESET   = 32'd25454545;

  localparam logic [RATE_W-1:0]  RATE_MAX  = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Timeout compare is done at the wider of the counter and register widths.
  localparam int CMP_W = (COUNT_W > TIMEOUT_W) ? COUNT_W : TIMEOUT_W;

  // History ring and running sum.
  localparam int SLOT_W = $clog2(HIST_DEPTH);
  localparam int SUM_W  = RATE_W + $clog2(HIST_DEPTH);

  // The average is sum / HIST_DEPTH, done as a multiply by a rounded-up
  // reciprocal. With the shift at SUM_W plus the divisor's bit length the
  // result is exact for every sum below 2**SUM_W.
  localparam int AVG_SHIFT = SUM_W + $clog2(HIST_DEPTH);
  localparam int MUL_W     = SUM_W + 1;
  localparam logic [63:0] AVG_MULT_FULL =
    ((64'd1 << AVG_SHIFT) + 64'(HIST_DEPTH) - 64'd1) / 64'(HIST_DEPTH);
  localparam logic [MUL_W-1:0] AVG_MULT = AVG_MULT_FULL[MUL_W-1:0];

  // Serial divider: one quotient bit per cycle.
  localparam int ITER_W = $clog2(NUM_W);

  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified item as handed from the front to the back.
  typedef struct packed {
    logic               is_edge;   // sensor edge, needs a rate update
    logic [COUNT_W-1:0] count;     // tick count captured at the edge
    logic               shutoff;   // timeout shut the pump off on this tick
    logic               counting;  // counter state after the item
  } fmts_job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fmts_qstat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_UPD,
    BK_AVG,
    BK_DONE
  } fmts_bstate_t;

endpackage

@@ design/flow_meter_with_timeout_shutoff.sv @@
// ----------------------------------------------------------------------------
// Pulse-period flow meter with timeout pump shutoff
// Measures ticks between sensor edges, turns them into a flow rate, keeps a
// history average and requests a pump stop when edges stop coming.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one item per timer tick (in_command 0) or per
//   sensor rising edge (in_command 1), with in_pump_running alongside. Every
//   accepted item produces exactly one result on the output channel, in order.
//   The cfg channel writes timeout_ticks (index 0) and rate_numerator
//   (index 1); other indexes are ignored. cfg_ready is always high, and the
//   registers should only be written while no items are in flight.
//   A tick needs no divide in the back part, so ticks flow at one per cycle
//   while no edge is in the back part and out_stall is low; a tick's result
//   passes through the queue and then the result register. An edge runs a
//   bit-serial divide of rate_numerator by the tick count, then the history
//   and change update, then the average multiply, before its result is
//   written. The back part takes no new item until it has written that result.
//   A two-entry queue lets the front keep taking items while the back part
//   divides; in_stall rises only when that queue is full. When the receiver
//   holds out_stall, the result register keeps its value and the back part
//   stops once its next result is ready.
//   Reset (rst_n low, synchronous) clears the counter, the history ring, the
//   previous rate and change, and restores both registers to their defaults.
// ----------------------------------------------------------------------------
module flow_meter_with_timeout_shutoff (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_command,
  input  logic                                in_pump_running,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [fmts_pkg::RATE_W-1:0]         out_latest_rate,
  output logic [fmts_pkg::RATE_W-1:0]         out_average_rate,
  output logic signed [fmts_pkg::RATE_W:0]    out_rate_change,
  output logic                                out_pump_off_request,
  output logic                                out_timer_running,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fmts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fmts_pkg::NUM_W-1:0]          cfg_data
);

  logic [fmts_pkg::TIMEOUT_W-1:0] timeout_r;
  logic [fmts_pkg::NUM_W-1:0]     numer_r;

  fmts_pkg::fmts_job_t   push_job, pop_job;
  fmts_pkg::fmts_qstat_t qstat;
  logic                  push, pop, back_busy;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= fmts_pkg::TIMEOUT_RESET;
      numer_r   <= fmts_pkg::NUMER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fmts_pkg::CFG_TIMEOUT: timeout_r <= cfg_data[fmts_pkg::TIMEOUT_W-1:0];
        fmts_pkg::CFG_NUMER:   numer_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // The front classifies each item and updates the tick counter at once.
  fmts_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_pump_running (in_pump_running),
    .timeout         (timeout_r),
    .qstat           (qstat),
    .push            (push),
    .job             (push_job)
  );

  fmts_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_job),
    .pop   (pop),
    .rdata (pop_job),
    .qstat (qstat)
  );

  // The back part owns the rate state and the result register.
  fmts_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .numerator            (numer_r),
    .job                  (pop_job),
    .qstat                (qstat),
    .pop                  (pop),
    .busy                 (back_busy),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_latest_rate      (out_latest_rate),
    .out_average_rate     (out_average_rate),
    .out_rate_change      (out_rate_change),
    .out_pump_off_request (out_pump_off_request),
    .out_timer_running    (out_timer_running)
  );

  // A shutoff result always reports the counter as stopped.
  a_off_stops_timer: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_pump_off_request) |-> !out_timer_running
  ) else $error("pump-off result shows the timer still running");

  // A new result needs a queued item or a rate update in progress.
  a_result_has_source: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!qstat.empty || back_busy)
  ) else $error("result appeared with no item behind it");

  // The queue never takes an item while full.
  a_no_push_when_full: assert property (
    @(posedge clk) disable iff (!rst_n)
    qstat.full |-> !push
  ) else $error("item pushed into a full queue");

endmodule

@@ design/fmts_front.sv @@
// ----------------------------------------------------------------------------
// Flow meter front part
// Accepts items, runs the edge-to-edge tick counter and timeout check.
// ----------------------------------------------------------------------------
module fmts_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_command,
  input  logic                            in_pump_running,
  input  logic [fmts_pkg::TIMEOUT_W-1:0]  timeout,
  input  fmts_pkg::fmts_qstat_t           qstat,
  output logic                            push,
  output fmts_pkg::fmts_job_t             job
);

  logic [fmts_pkg::COUNT_W-1:0] tick_r, tick_nxt, tick_inc;
  logic                         counting_r, counting_nxt;

  assign in_stall = qstat.full;
  assign push     = in_valid && !qstat.full;

  always_comb begin
    tick_nxt     = tick_r;
    counting_nxt = counting_r;
    tick_inc     = (tick_r == fmts_pkg::COUNT_MAX) ? tick_r
                                                   : tick_r + 1'b1;
    job.is_edge  = in_command;
    job.count    = tick_r;
    job.shutoff  = 1'b0;
    if (in_command) begin
      tick_nxt     = '0;
      counting_nxt = 1'b1;
    end else if (counting_r) begin
      if (fmts_pkg::CMP_W'(tick_inc) >= fmts_pkg::CMP_W'(timeout)) begin
        // Timeout: the count restarts, and the pump is shut off if it runs.
        tick_nxt = '0;
        if (in_pump_running) begin
          job.shutoff  = 1'b1;
          counting_nxt = 1'b0;
        end
      end else begin
        tick_nxt = tick_inc;
      end
    end
    job.counting = counting_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r     <= '0;
      counting_r <= 1'b0;
    end else if (push) begin
      tick_r     <= tick_nxt;
      counting_r <= counting_nxt;
    end
  end

endmodule

@@ design/fmts_queue.sv @@
// ----------------------------------------------------------------------------
// Flow meter item queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module fmts_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  fmts_pkg::fmts_job_t   wdata,
  input  logic                  pop,
  output fmts_pkg::fmts_job_t   rdata,
  output fmts_pkg::fmts_qstat_t qstat
);

  fmts_pkg::fmts_job_t mem [fmts_pkg::QUEUE_DEPTH];

  logic [fmts_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [fmts_pkg::QCNT_W-1:0] cnt_r;

  function automatic logic [fmts_pkg::QPTR_W-1:0] ptr_inc(
    input logic [fmts_pkg::QPTR_W-1:0] p
  );
    return (p == fmts_pkg::QPTR_W'(fmts_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign qstat.empty = (cnt_r == '0);
  assign qstat.full  = (cnt_r == fmts_pkg::QCNT_W'(fmts_pkg::QUEUE_DEPTH));
  assign rdata       = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ design/fmts_back.sv @@
// ----------------------------------------------------------------------------
// Flow meter back part
// Serial rate divider, history ring, running average and result register.
// ----------------------------------------------------------------------------
module fmts_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [fmts_pkg::NUM_W-1:0]           numerator,
  input  fmts_pkg::fmts_job_t                  job,
  input  fmts_pkg::fmts_qstat_t                qstat,
  output logic                                 pop,
  output logic                                 busy,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [fmts_pkg::RATE_W-1:0]          out_latest_rate,
  output logic [fmts_pkg::RATE_W-1:0]          out_average_rate,
  output logic signed [fmts_pkg::RATE_W:0]     out_rate_change,
  output logic                                 out_pump_off_request,
  output logic                                 out_timer_running
);

  fmts_pkg::fmts_bstate_t state_r, state_nxt;

  // Divider.
  logic [fmts_pkg::ITER_W-1:0]  iter_r, iter_nxt;
  logic [fmts_pkg::COUNT_W-1:0] rem_r, rem_nxt;
  logic [fmts_pkg::COUNT_W-1:0] dvsr_r, dvsr_nxt;
  logic [fmts_pkg::NUM_W-1:0]   quo_r, quo_nxt;
  logic [fmts_pkg::COUNT_W:0]   shifted, diff;

  // Rate state.
  logic [fmts_pkg::RATE_W-1:0]        hist_r [fmts_pkg::HIST_DEPTH];
  logic                               hist_we;
  logic [fmts_pkg::SLOT_W-1:0]        slot_r, slot_nxt;
  logic [fmts_pkg::SUM_W-1:0]         sum_r, sum_nxt;
  logic [fmts_pkg::RATE_W-1:0]        prev_r, prev_nxt;
  logic signed [fmts_pkg::RATE_W:0]   change_r, change_nxt;
  logic [fmts_pkg::RATE_W-1:0]        avg_r, avg_nxt;
  logic [fmts_pkg::RATE_W-1:0]        rate_c;
  logic [fmts_pkg::SUM_W+fmts_pkg::MUL_W-1:0] prod;

  // Result register.
  logic                               ov_r, ov_nxt;
  logic [fmts_pkg::RATE_W-1:0]        o_latest_r, o_latest_nxt;
  logic [fmts_pkg::RATE_W-1:0]        o_avg_r, o_avg_nxt;
  logic signed [fmts_pkg::RATE_W:0]   o_change_r, o_change_nxt;
  logic                               o_off_r, o_off_nxt;
  logic                               o_run_r, o_run_nxt;
  logic                               out_free;

  assign out_free = !ov_r || !out_stall;
  assign busy     = (state_r != fmts_pkg::BK_IDLE);

  assign shifted = {rem_r, quo_r[fmts_pkg::NUM_W-1]};
  assign diff    = shifted - {1'b0, dvsr_r};

  // A zero period and a quotient above the rate range both give the maximum.
  assign rate_c = ((dvsr_r == '0) ||
                   (quo_r > fmts_pkg::NUM_W'(fmts_pkg::RATE_MAX)))
                  ? fmts_pkg::RATE_MAX : quo_r[fmts_pkg::RATE_W-1:0];

  assign prod = {{fmts_pkg::MUL_W{1'b0}}, sum_r} *
                {{fmts_pkg::SUM_W{1'b0}}, fmts_pkg::AVG_MULT};

  always_comb begin
    state_nxt    = state_r;
    iter_nxt     = iter_r;
    rem_nxt      = rem_r;
    dvsr_nxt     = dvsr_r;
    quo_nxt      = quo_r;
    slot_nxt     = slot_r;
    sum_nxt      = sum_r;
    prev_nxt     = prev_r;
    change_nxt   = change_r;
    avg_nxt      = avg_r;
    hist_we      = 1'b0;
    pop          = 1'b0;
    ov_nxt       = ov_r && out_stall;
    o_latest_nxt = o_latest_r;
    o_avg_nxt    = o_avg_r;
    o_change_nxt = o_change_r;
    o_off_nxt    = o_off_r;
    o_run_nxt    = o_run_r;

    unique case (state_r)
      fmts_pkg::BK_IDLE: begin
        if (!qstat.empty && (job.is_edge || out_free)) begin
          pop = 1'b1;
          if (job.is_edge) begin
            dvsr_nxt  = job.count;
            quo_nxt   = numerator;
            rem_nxt   = '0;
            iter_nxt  = fmts_pkg::ITER_W'(fmts_pkg::NUM_W - 1);
            state_nxt = fmts_pkg::BK_DIV;
          end else begin
            // A tick leaves the rate state alone and reports it as it is.
            ov_nxt       = 1'b1;
            o_latest_nxt = prev_r;
            o_avg_nxt    = avg_r;
            o_change_nxt = change_r;
            o_off_nxt    = job.shutoff;
            o_run_nxt    = job.counting;
          end
        end
      end
      fmts_pkg::BK_DIV: begin
        rem_nxt = diff[fmts_pkg::COUNT_W] ? shifted[fmts_pkg::COUNT_W-1:0]
                                          : diff[fmts_pkg::COUNT_W-1:0];
        quo_nxt = {quo_r[fmts_pkg::NUM_W-2:0], ~diff[fmts_pkg::COUNT_W]};
        if (iter_r == '0) begin
          state_nxt = fmts_pkg::BK_UPD;
        end else begin
          iter_nxt = iter_r - 1'b1;
        end
      end
      fmts_pkg::BK_UPD: begin
        hist_we    = 1'b1;
        prev_nxt   = rate_c;
        change_nxt = $signed({1'b0, rate_c}) - $signed({1'b0, prev_r});
        sum_nxt    = sum_r - fmts_pkg::SUM_W'(hist_r[slot_r])
                           + fmts_pkg::SUM_W'(rate_c);
        slot_nxt   = (slot_r == fmts_pkg::SLOT_W'(fmts_pkg::HIST_DEPTH - 1))
                     ? '0 : slot_r + 1'b1;
        state_nxt  = fmts_pkg::BK_AVG;
      end
      fmts_pkg::BK_AVG: begin
        avg_nxt   = prod[fmts_pkg::AVG_SHIFT +: fmts_pkg::RATE_W];
        state_nxt = fmts_pkg::BK_DONE;
      end
      fmts_pkg::BK_DONE: begin
        if (out_free) begin
          // An edge always leaves the counter running.
          ov_nxt       = 1'b1;
          o_latest_nxt = prev_r;
          o_avg_nxt    = avg_r;
          o_change_nxt = change_r;
          o_off_nxt    = 1'b0;
          o_run_nxt    = 1'b1;
          state_nxt    = fmts_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = fmts_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= fmts_pkg::BK_IDLE;
      ov_r     <= 1'b0;
      slot_r   <= '0;
      sum_r    <= '0;
      prev_r   <= '0;
      change_r <= '0;
      avg_r    <= '0;
      for (int i = 0; i < fmts_pkg::HIST_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      ov_r     <= ov_nxt;
      slot_r   <= slot_nxt;
      sum_r    <= sum_nxt;
      prev_r   <= prev_nxt;
      change_r <= change_nxt;
      avg_r    <= avg_nxt;
      if (hist_we) begin
        hist_r[slot_r] <= rate_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    iter_r     <= iter_nxt;
    rem_r      <= rem_nxt;
    dvsr_r     <= dvsr_nxt;
    quo_r      <= quo_nxt;
    o_latest_r <= o_latest_nxt;
    o_avg_r    <= o_avg_nxt;
    o_change_r <= o_change_nxt;
    o_off_r    <= o_off_nxt;
    o_run_r    <= o_run_nxt;
  end

  assign out_valid            = ov_r;
  assign out_latest_rate      = o_latest_r;
  assign out_average_rate     = o_avg_r;
  assign out_rate_change      = o_change_r;
  assign out_pump_off_request = o_off_r;
  assign out_timer_running    = o_run_r;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Flow meter testbench
// Drives timer ticks and sensor edges into the flow meter, predicts every
// result with a cycle-free model of the meter, and checks each result field
// by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  // Item commands on the input channel.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_EDGE = 1'b1;

  // Register indexes that decode to nothing. Writes to them must be ignored.
  localparam logic [fmts_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [fmts_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  // SETTLE_CYCLES quiet cycles after the last result leave the back part idle.
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 1950;
  localparam int PHASES        = 13;

  // One result of the meter as seen on the output channel.
  typedef struct packed {
    logic [fmts_pkg::RATE_W-1:0]      latest;
    logic [fmts_pkg::RATE_W-1:0]      average;
    logic signed [fmts_pkg::RATE_W:0] change;
    logic                             stop_req;
    logic                             running;
  } reading_t;

  // All inputs start at known values. Reset is held low for the first cycles.
  logic                           clk             = 1'b0;
  logic                           rst_n           = 1'b0;
  logic                           in_valid        = 1'b0;
  logic                           in_command      = 1'b0;
  logic                           in_pump_running = 1'b0;
  logic                           out_stall       = 1'b0;
  logic                           cfg_valid       = 1'b0;
  logic [fmts_pkg::CFG_IDX_W-1:0] cfg_index       = '0;
  logic [fmts_pkg::NUM_W-1:0]     cfg_data        = '0;

  logic                             in_stall;
  logic                             out_valid;
  logic [fmts_pkg::RATE_W-1:0]      out_latest_rate;
  logic [fmts_pkg::RATE_W-1:0]      out_average_rate;
  logic signed [fmts_pkg::RATE_W:0] out_rate_change;
  logic                             out_pump_off_request;
  logic                             out_timer_running;
  logic                             cfg_ready;

  flow_meter_with_timeout_shutoff dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_command           (in_command),
    .in_pump_running      (in_pump_running),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_latest_rate      (out_latest_rate),
    .out_average_rate     (out_average_rate),
    .out_rate_change      (out_rate_change),
    .out_pump_off_request (out_pump_off_request),
    .out_timer_running    (out_timer_running),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Meter model. It holds its own copy of the registers and of the counter,
  // ring and rate state, and advances one item at a time.
  // --------------------------------------------------------------------------
  logic [fmts_pkg::TIMEOUT_W-1:0]   model_timeout;
  logic [fmts_pkg::NUM_W-1:0]       model_numer;
  logic [fmts_pkg::COUNT_W-1:0]     model_ticks;
  logic                             model_counting;
  logic [fmts_pkg::RATE_W-1:0]      model_ring [fmts_pkg::HIST_DEPTH];
  int                               model_slot;
  logic [fmts_pkg::RATE_W-1:0]      model_last_rate;
  logic signed [fmts_pkg::RATE_W:0] model_delta;

  // Expected readings, oldest first, in the order the items were accepted.
  reading_t expected_readings[$];
  reading_t oldest;

  int fail_count    = 0;
  int items_sent    = 0;
  int edges_sent    = 0;
  int shutoffs_seen = 0;
  int results_seen  = 0;
  int cfg_writes    = 0;
  int burst_left    = 0;
  int gap_limit     = 4;
  int rx_cycle      = 0;

  function automatic void meter_reset();
    model_timeout   = fmts_pkg::TIMEOUT_RESET;
    model_numer     = fmts_pkg::NUMER_RESET;
    model_ticks     = '0;
    model_counting  = 1'b0;
    foreach (model_ring[i]) model_ring[i] = '0;
    model_slot      = 0;
    model_last_rate = '0;
    model_delta     = '0;
  endfunction

  function automatic void meter_config(input logic [fmts_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [fmts_pkg::NUM_W-1:0] data);
    case (idx)
      fmts_pkg::CFG_TIMEOUT: model_timeout = data[fmts_pkg::TIMEOUT_W-1:0];
      fmts_pkg::CFG_NUMER:   model_numer   = data;
      default: ;
    endcase
  endfunction

  function automatic reading_t meter_step(input logic cmd, input logic pump);
    logic [fmts_pkg::NUM_W-1:0] quot;
    logic [fmts_pkg::RATE_W-1:0] rate;
    logic [31:0] ring_sum;
    reading_t r;
    r.stop_req = 1'b0;
    if (cmd == CMD_EDGE) begin
      // A zero count, the first edge among them, reads as the fastest flow.
      // A quotient beyond the rate range clips to the maximum as well.
      if (model_ticks == '0) begin
        rate = fmts_pkg::RATE_MAX;
      end else begin
        quot = model_numer / model_ticks;
        rate = (quot > fmts_pkg::RATE_MAX) ? fmts_pkg::RATE_MAX
                                           : quot[fmts_pkg::RATE_W-1:0];
      end
      model_ticks     = '0;
      model_counting  = 1'b1;
      model_delta     = $signed({1'b0, rate}) - $signed({1'b0, model_last_rate});
      model_last_rate = rate;
      model_ring[model_slot] = rate;
      model_slot = (model_slot == fmts_pkg::HIST_DEPTH - 1) ? 0 : model_slot + 1;
    end else if (model_counting) begin
      if (model_ticks != fmts_pkg::COUNT_MAX) model_ticks = model_ticks + 1'b1;
      // Reaching the timeout always restarts the count; only a running pump
      // turns it into a shutoff that stops the timer.
      if (model_ticks >= model_timeout) begin
        model_ticks = '0;
        if (pump) begin
          r.stop_req     = 1'b1;
          model_counting = 1'b0;
        end
      end
    end
    ring_sum = '0;
    foreach (model_ring[i]) ring_sum = ring_sum + model_ring[i];
    r.latest  = model_last_rate;
    r.average = fmts_pkg::RATE_W'(ring_sum / fmts_pkg::HIST_DEPTH);
    r.change  = model_delta;
    r.running = model_counting;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result side. The receiver stalls on a pattern of its own that cycles
  // through four modes: never, light random, heavy random and periodic.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 600) % 4)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= ((rx_cycle % 11) < 4);
    endcase
  end

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Every accepted result is matched against the oldest expected reading.
  // Values are read right after the edge, so they are the ones the edge saw.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_readings.size() == 0) begin
        $error("result arrived with no expected reading pending");
        fail_count++;
      end else begin
        oldest = expected_readings.pop_front();
        check_field("latest_rate", oldest.latest, out_latest_rate);
        check_field("average_rate", oldest.average, out_average_rate);
        check_field("rate_change", $signed(oldest.change), out_rate_change);
        check_field("pump_off_request", oldest.stop_req, out_pump_off_request);
        check_field("timer_running", oldest.running, out_timer_running);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side. Items go out in bursts of random length; after each burst the
  // sender may drop valid for a random gap. The payload holds while stalled.
  // A valid that stays high for the next item is never lowered in between.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic cmd, input logic pump);
    int gap;
    reading_t r;
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_pump_running <= pump;
    do @(posedge clk); while (in_stall);
    r = meter_step(cmd, pump);
    expected_readings.push_back(r);
    items_sent++;
    if (cmd == CMD_EDGE) edges_sent++;
    if (r.stop_req) shutoffs_seen++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, gap_limit);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
  endtask

  // Stops sending and waits until every expected reading has come back, then
  // lets the back part run out before anything else happens.
  task automatic settle();
    if (in_valid) in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers while the meter is idle. Optionally one of the
  // undecoded indexes is written first with random data. The timeout write
  // carries random upper bits, which the register must drop.
  task automatic apply_config(input logic [fmts_pkg::TIMEOUT_W-1:0] t,
                              input logic [fmts_pkg::NUM_W-1:0] n,
                              input bit poke_spare);
    logic [fmts_pkg::CFG_IDX_W-1:0] idx [3];
    logic [fmts_pkg::NUM_W-1:0] val [3];
    int first;
    settle();
    idx[0] = $urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO;
    idx[1] = fmts_pkg::CFG_TIMEOUT;
    idx[2] = fmts_pkg::CFG_NUMER;
    val[0] = $urandom;
    val[1] = {16'($urandom), t};
    val[2] = n;
    first = poke_spare ? 0 : 1;
    for (int k = first; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      meter_config(idx[k], val[k]);
      cfg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Default registers straight out of reset. A tick before any edge must do
  // nothing. The first edge sees a zero count and reads as maximum flow. A
  // three-tick period gives a rate in range, and a one-tick period overflows
  // the rate range with the default numerator and must clip.
  task automatic test_reset_state();
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_EDGE, 1'b1);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_EDGE, 1'b0);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_EDGE, 1'b1);
  endtask

  // Register extremes. With a zero timeout every counted tick times out: with
  // the pump off the count just restarts, with it on the pump is shut off and
  // the following tick is ignored. A zero numerator gives a zero rate and a
  // large negative change. A numerator of one gives the smallest nonzero
  // rate, then a short timeout ends in a shutoff.
  task automatic test_register_extremes();
    apply_config('0, '1, 1'b1);
    send_item(CMD_EDGE, 1'b0);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_EDGE, 1'b0);
    apply_config('1, '0, 1'b1);
    send_item(CMD_EDGE, 1'b1);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_EDGE, 1'b0);
    apply_config(16'd3, 32'd1, 1'b0);
    send_item(CMD_EDGE, 1'b1);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_EDGE, 1'b0);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_TICK, 1'b1);
  endtask

  // Random traffic in phases, each with its own register setting and sender
  // gap limit. Most of the traffic is sensor periods: an edge followed by a
  // run of ticks sized around a short timeout, with the pump mostly steady, so
  // that rates, timeouts and shutoffs all come up. The rest is random noise.
  // Halfway through, the sender holds off until every result is back.
  task automatic test_random_traffic();
    logic [fmts_pkg::TIMEOUT_W-1:0] t;
    logic [fmts_pkg::NUM_W-1:0] n;
    logic pump;
    int quota;
    int phase_items;
    int run_len;
    bit paused;
    quota  = RANDOM_ITEMS / PHASES;
    paused = 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       t = '0;
        1:       t = '1;
        2:       t = 16'd1;
        default: t = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(2, 60));
      endcase
      case ($urandom_range(0, 4))
        0:       n = '1;
        1:       n = 32'($urandom_range(1, 1000));
        2:       n = 32'd1;
        default: n = $urandom;
      endcase
      gap_limit = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 3 : 12);
      apply_config(t, n, 1'(p % 2));
      phase_items = 0;
      while (phase_items < quota) begin
        if ($urandom_range(0, 3) != 0) begin
          pump = 1'($urandom_range(0, 1));
          send_item(CMD_EDGE, 1'($urandom_range(0, 1)));
          run_len = (t <= 60) ? $urandom_range(0, t + 3) : $urandom_range(0, 40);
          for (int k = 0; k < run_len; k++)
            send_item(CMD_TICK, ($urandom_range(0, 9) == 0) ? !pump : pump);
          phase_items += run_len + 1;
        end else begin
          run_len = $urandom_range(1, 8);
          for (int k = 0; k < run_len; k++)
            send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          phase_items += run_len;
        end
        if (p == PHASES / 2 && !paused && phase_items >= quota / 2) begin
          settle();
          paused = 1'b1;
        end
      end
    end
  endtask

  // Main sequence: reset once, then the tests in turn, then drain and report.
  initial begin
    meter_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_register_extremes();
    test_random_traffic();
    settle();
    $display("Sent %0d items including %0d sensor edges; %0d pump shutoffs occurred.",
             items_sent, edges_sent, shutoffs_seen);
    $display("Checked %0d results across %0d register writes.", results_seen, cfg_writes);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog. The slowest correct run stays far below this.
  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ flow_meter_with_timeout_shutoff.f @@
design/fmts_pkg.sv
design/fmts_front.sv
design/fmts_queue.sv
design/fmts_back.sv
design/flow_meter_with_timeout_shutoff.sv
tb/tb_top.sv
